// ===== design/frame_difference_color_change_detector_defines.svh =====
// assertion macros used by the frame tally module of the frame difference detector
// expects clk_i and the active-low rst_ni in the scope of each use
`ifndef FRAME_DIFFERENCE_COLOR_CHANGE_DETECTOR_DEFINES_SVH
`define FRAME_DIFFERENCE_COLOR_CHANGE_DETECTOR_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define FDCC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define FDCC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FDCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fdcc_pkg.sv =====
// shared types and constants of the frame difference color change detector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fdcc_pkg;

  localparam int PIX_W        = 8;
  localparam int CFG_DIM_W    = 13;
  localparam int CFG_ROW_W    = 12;
  localparam int CFG_THR_W    = 8;
  localparam int CFG_CNT_W    = 24;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int OUT_COUNT_W  = 24;

  localparam int DEF_DIM_BITS   = 12;
  localparam int DEF_COUNT_BITS = 24;

  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_WIDTH       = 13'd640;
  localparam logic [CFG_DIM_W-1:0] RST_IMAGE_HEIGHT      = 13'd480;
  localparam logic [CFG_ROW_W-1:0] RST_START_ROW         = 12'd300;
  localparam logic [CFG_THR_W-1:0] RST_CHANNEL_THRESHOLD = 8'd40;
  localparam logic [CFG_CNT_W-1:0] RST_COUNT_THRESHOLD   = 24'd1250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH       = 3'd0,
    CFG_IMAGE_HEIGHT      = 3'd1,
    CFG_START_ROW         = 3'd2,
    CFG_CHANNEL_THRESHOLD = 3'd3,
    CFG_COUNT_THRESHOLD   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_DIM_W-1:0] image_width;
    logic [CFG_DIM_W-1:0] image_height;
    logic [CFG_ROW_W-1:0] start_row;
    logic [CFG_THR_W-1:0] channel_threshold;
    logic [CFG_CNT_W-1:0] count_threshold;
  } cfg_t;

  // pixel presented to the frame tally
  typedef struct packed {
    logic vld;
    logic hit;
  } pix_t;

endpackage

`default_nettype wire

// ===== design/fdcc_pixel_test.sv =====
// per-pixel color change test: channel differences and pairwise threshold
// depends on fdcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module fdcc_pixel_test
  import fdcc_pkg::*;
(
  input  wire logic [PIX_W-1:0]     cur_blue_i,
  input  wire logic [PIX_W-1:0]     cur_green_i,
  input  wire logic [PIX_W-1:0]     cur_red_i,
  input  wire logic [PIX_W-1:0]     prev_blue_i,
  input  wire logic [PIX_W-1:0]     prev_green_i,
  input  wire logic [PIX_W-1:0]     prev_red_i,
  input  wire logic [CFG_THR_W-1:0] threshold_i,
  output logic                      hit_o
);

  function automatic logic [PIX_W-1:0] sat_sub(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  logic [PIX_W-1:0] diff_b, diff_g, diff_r;

  always_comb begin
    diff_b = sat_sub(cur_blue_i, prev_blue_i);
    diff_g = sat_sub(cur_green_i, prev_green_i);
    diff_r = sat_sub(cur_red_i, prev_red_i);
    hit_o  = (abs_diff(diff_b, diff_g) > threshold_i) ||
             (abs_diff(diff_b, diff_r) > threshold_i) ||
             (abs_diff(diff_r, diff_g) > threshold_i);
  end

endmodule

`default_nettype wire

// ===== design/fdcc_frame_tally.sv =====
// raster position tracking, saturating changed-pixel tally, barrier flag
// and the registered result beat; depends on fdcc_pkg and the defines header
`timescale 1ns / 1ps
`default_nettype none
`include "frame_difference_color_change_detector_defines.svh"

module fdcc_frame_tally
  import fdcc_pkg::*;
#(
  parameter int DIM_BITS   = DEF_DIM_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire pix_t                   pix_i,
  output logic                        take_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        barrier_present_o,
  output logic                        barrier_changed_o,
  output logic [OUT_COUNT_W-1:0]      changed_pixel_count_o
);

  localparam int CmpW = (DIM_BITS + 1 > CFG_DIM_W) ? DIM_BITS + 1 : CFG_DIM_W;
  localparam int RowW = (DIM_BITS > CFG_ROW_W) ? DIM_BITS : CFG_ROW_W;
  localparam int ThW  = (COUNT_BITS > CFG_CNT_W) ? COUNT_BITS : CFG_CNT_W;
  localparam logic [CmpW-1:0] DimOne = {{(CmpW-1){1'b0}}, 1'b1};
  localparam logic [CmpW-1:0] DimTop = DimOne << DIM_BITS;
  localparam logic [OUT_COUNT_W-1:0] ShowMax = '1;

  logic [DIM_BITS-1:0]   col_q, col_d, row_q, row_d;
  logic [COUNT_BITS-1:0] tally_q, tally_d, tally_inc;
  logic                  flag_q, flag_d;
  logic                  out_vld_q, out_vld_d;
  logic                  present_q, changed_q;
  logic [OUT_COUNT_W-1:0] count_q;

  logic [CmpW-1:0] w_ext, h_ext, w_eff, h_eff, col_next, row_next;
  logic [ThW-1:0]  tally_ext;
  logic            row_ok, last_col, last_row, last_pix, out_ready, present;
  logic            frame_take;
  logic [OUT_COUNT_W-1:0] shown;

  always_comb begin
    w_ext = CmpW'(cfg_i.image_width);
    h_ext = CmpW'(cfg_i.image_height);
    // zero acts as one, oversize clamps to the position range
    w_eff = (w_ext == '0) ? DimOne : ((w_ext > DimTop) ? DimTop : w_ext);
    h_eff = (h_ext == '0) ? DimOne : ((h_ext > DimTop) ? DimTop : h_ext);

    col_next = CmpW'(col_q) + DimOne;
    row_next = CmpW'(row_q) + DimOne;
    last_col = col_next >= w_eff;
    last_row = row_next >= h_eff;
    last_pix = last_col && last_row;

    row_ok    = RowW'(row_q) >= RowW'(cfg_i.start_row);
    tally_inc = (pix_i.hit && row_ok && (tally_q != '1)) ? tally_q + 1'b1 : tally_q;
    tally_ext = ThW'(tally_inc);
    present   = tally_ext > ThW'(cfg_i.count_threshold);
    shown     = (tally_ext > ThW'(ShowMax)) ? ShowMax : OUT_COUNT_W'(tally_ext);

    out_ready  = !out_vld_q || !out_stall_i;
    take_o     = pix_i.vld && (!last_pix || out_ready);
    frame_take = take_o && last_pix;

    col_d   = col_q;
    row_d   = row_q;
    tally_d = tally_q;
    flag_d  = flag_q;
    if (take_o) begin
      col_d   = last_col ? '0 : col_next[DIM_BITS-1:0];
      tally_d = last_pix ? '0 : tally_inc;
      if (last_col) begin
        row_d = last_row ? '0 : row_next[DIM_BITS-1:0];
      end
      if (last_pix) begin
        flag_d = present;
      end
    end

    out_vld_d = out_vld_q;
    if (frame_take) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      tally_q   <= '0;
      flag_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      tally_q   <= tally_d;
      flag_q    <= flag_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_take) begin
      present_q <= present;
      changed_q <= present ^ flag_q;
      count_q   <= shown;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign barrier_present_o     = present_q;
  assign barrier_changed_o     = changed_q;
  assign changed_pixel_count_o = count_q;

  `FDCC_ASSERT(a_no_overwrite, !(frame_take && out_vld_q && out_stall_i), "result beat overwritten")
  `FDCC_ASSERT_IMPL(a_rise_from_frame, $rose(out_vld_q), $past(frame_take), "result without frame end")
  `FDCC_ASSERT_NEXT(a_tally_cleared, frame_take, tally_q == '0, "tally not cleared at frame end")
  `FDCC_ASSERT_NEXT(a_row_holds, take_o && !last_col, row_q == $past(row_q), "row moved mid-row")

endmodule

`default_nettype wire

// ===== design/frame_difference_color_change_detector.sv =====
// channel    | handshake                   | payload
// cfg        | cfg_valid_i / cfg_ready_o   | cfg_index_i, cfg_data_i
// pixel in   | in_valid_i / in_stall_o     | cur_* and prev_* bytes
// result out | out_valid_o / out_stall_i   | barrier_present, barrier_changed, count
//
// one pixel beat is taken every cycle while no stalled result holds the frame's last
// pixel; a result passes through the input register and then the result register
// reset clears positions, tally and barrier flag and loads register defaults
// a full result register under stall holds back only the frame's last pixel
// top level: config registers and pixel input register; depends on fdcc_pkg,
// fdcc_pixel_test and fdcc_frame_tally
`timescale 1ns / 1ps
`default_nettype none

module frame_difference_color_change_detector
  import fdcc_pkg::*;
#(
  parameter int DIM_BITS   = DEF_DIM_BITS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [PIX_W-1:0]       cur_blue_i,
  input  wire logic [PIX_W-1:0]       cur_green_i,
  input  wire logic [PIX_W-1:0]       cur_red_i,
  input  wire logic [PIX_W-1:0]       prev_blue_i,
  input  wire logic [PIX_W-1:0]       prev_green_i,
  input  wire logic [PIX_W-1:0]       prev_red_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        barrier_present_o,
  output logic                        barrier_changed_o,
  output logic [OUT_COUNT_W-1:0]      changed_pixel_count_o
);

  cfg_t cfg_q, cfg_d;

  logic             s1_vld_q, s1_vld_d;
  logic [PIX_W-1:0] cb_q, cg_q, cr_q, pb_q, pg_q, pr_q;
  logic             accept, take, hit;
  pix_t             pix;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:       cfg_d.image_width       = cfg_data_i[CFG_DIM_W-1:0];
        CFG_IMAGE_HEIGHT:      cfg_d.image_height      = cfg_data_i[CFG_DIM_W-1:0];
        CFG_START_ROW:         cfg_d.start_row         = cfg_data_i[CFG_ROW_W-1:0];
        CFG_CHANNEL_THRESHOLD: cfg_d.channel_threshold = cfg_data_i[CFG_THR_W-1:0];
        CFG_COUNT_THRESHOLD:   cfg_d.count_threshold   = cfg_data_i[CFG_CNT_W-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  // input register frees up when the tally takes its beat
  assign in_stall_o = s1_vld_q && !take;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (take) begin
      s1_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width       <= RST_IMAGE_WIDTH;
      cfg_q.image_height      <= RST_IMAGE_HEIGHT;
      cfg_q.start_row         <= RST_START_ROW;
      cfg_q.channel_threshold <= RST_CHANNEL_THRESHOLD;
      cfg_q.count_threshold   <= RST_COUNT_THRESHOLD;
      s1_vld_q                <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cb_q <= cur_blue_i;
      cg_q <= cur_green_i;
      cr_q <= cur_red_i;
      pb_q <= prev_blue_i;
      pg_q <= prev_green_i;
      pr_q <= prev_red_i;
    end
  end

  fdcc_pixel_test u_pixel_test (
    .cur_blue_i   (cb_q),
    .cur_green_i  (cg_q),
    .cur_red_i    (cr_q),
    .prev_blue_i  (pb_q),
    .prev_green_i (pg_q),
    .prev_red_i   (pr_q),
    .threshold_i  (cfg_q.channel_threshold),
    .hit_o        (hit)
  );

  assign pix.vld = s1_vld_q;
  assign pix.hit = hit;

  fdcc_frame_tally #(
    .DIM_BITS   (DIM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_frame_tally (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .pix_i                 (pix),
    .take_o                (take),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .barrier_present_o     (barrier_present_o),
    .barrier_changed_o     (barrier_changed_o),
    .changed_pixel_count_o (changed_pixel_count_o)
  );

endmodule

`default_nettype wire
